@@ src/rcc_pkg.sv @@
// Shared types, codes and defaults of the two-generation run cache.
package rcc_pkg;

  localparam int unsigned SLOTS_DEF    = 64;
  localparam int unsigned TAG_BITS_DEF = 32;

  localparam int unsigned CAPACITY_W = 7;
  localparam int unsigned BUDGET_W   = 22;
  localparam int unsigned RUN_W      = 16;
  localparam int unsigned VAR_W      = 8;
  localparam int unsigned IN_TAG_W   = 32;
  localparam int unsigned SLOT_W     = 7;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [CAPACITY_W-1:0] CAPACITY_RST = 7'd64;
  localparam logic [BUDGET_W-1:0]   BUDGET_RST   = 22'd65536;
  localparam logic [RUN_W-1:0]      MAX_RUN_RST  = 16'd1024;

  typedef enum logic [2:0] {
    ST_HOT_HIT  = 3'd0,
    ST_COLD_HIT = 3'd1,
    ST_MISS     = 3'd2,
    ST_LONG     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY    = 2'd0,
    REG_UNIT_BUDGET = 2'd1,
    REG_MAX_RUN     = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic hot_hit;
    logic cold_hit;
    logic free_any;
    logic free_rot;
  } scan_flags_t;

endpackage

@@ src/rcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rcc_scan.sv @@
// Shared key comparator and free-entry tracker, fed one entry per cycle.
module rcc_scan #(
  parameter int unsigned IDX_W    = 7,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      pend_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  logic                      ent_valid_i,
  input  logic                      ent_hot_i,
  input  logic [KEY_BITS-1:0]       rd_tag_i,
  input  logic [rcc_pkg::VAR_W-1:0] rd_var_i,
  input  logic [rcc_pkg::RUN_W-1:0] rd_units_i,
  input  logic [KEY_BITS-1:0]       key_tag_i,
  input  logic [rcc_pkg::VAR_W-1:0] key_var_i,
  output rcc_pkg::scan_flags_t      flags_o,
  output logic [IDX_W-1:0]          hot_idx_o,
  output logic [IDX_W-1:0]          cold_idx_o,
  output logic [rcc_pkg::RUN_W-1:0] cold_units_o,
  output logic [IDX_W-1:0]          free_idx_o,
  output logic [IDX_W-1:0]          free_rot_idx_o
);

  rcc_pkg::scan_flags_t      flags_q, flags_d;
  logic [IDX_W-1:0]          hot_idx_q, hot_idx_d;
  logic [IDX_W-1:0]          cold_idx_q, cold_idx_d;
  logic [rcc_pkg::RUN_W-1:0] cold_units_q, cold_units_d;
  logic [IDX_W-1:0]          free_idx_q, free_idx_d;
  logic [IDX_W-1:0]          free_rot_idx_q, free_rot_idx_d;
  logic                      match;

  assign match = ent_valid_i && (rd_tag_i == key_tag_i) && (rd_var_i == key_var_i);

  always_comb begin
    flags_d        = flags_q;
    hot_idx_d      = hot_idx_q;
    cold_idx_d     = cold_idx_q;
    cold_units_d   = cold_units_q;
    free_idx_d     = free_idx_q;
    free_rot_idx_d = free_rot_idx_q;
    if (start_i) begin
      flags_d = '0;
    end else if (pend_i) begin
      // last hot match wins; otherwise the first cold match
      if (match && ent_hot_i) begin
        flags_d.hot_hit = 1'b1;
        hot_idx_d       = idx_i;
      end
      if (match && !ent_hot_i && !flags_q.cold_hit) begin
        flags_d.cold_hit = 1'b1;
        cold_idx_d       = idx_i;
        cold_units_d     = rd_units_i;
      end
      if (!ent_valid_i && !flags_q.free_any) begin
        flags_d.free_any = 1'b1;
        free_idx_d       = idx_i;
      end
      // free once hot has become cold and the old cold is gone
      if (!(ent_valid_i && ent_hot_i) && !flags_q.free_rot) begin
        flags_d.free_rot = 1'b1;
        free_rot_idx_d   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hot_idx_q      <= hot_idx_d;
    cold_idx_q     <= cold_idx_d;
    cold_units_q   <= cold_units_d;
    free_idx_q     <= free_idx_d;
    free_rot_idx_q <= free_rot_idx_d;
  end

  assign flags_o        = flags_q;
  assign hot_idx_o      = hot_idx_q;
  assign cold_idx_o     = cold_idx_q;
  assign cold_units_o   = cold_units_q;
  assign free_idx_o     = free_idx_q;
  assign free_rot_idx_o = free_rot_idx_q;

endmodule

@@ src/two_generation_run_cache_top.sv @@
// Top level of the two-generation run cache: sequencer, entry state and result register.
//
// Usage: items arrive on the s_axis channel; s_axis_tuser_i selects lookup (0) or
// clear of both generations (1), s_axis_tdata_i carries tag, variant and run length.
// Each item gives exactly one result on m_axis: tuser holds the status, tdata the
// slot, the rotation flag and the lifetime hit and miss counters after the item.
// Configuration (capacity, unit budget, longest cached run) is written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i, one register per cycle; the user must write it
// only while no item is open, as the block itself does not enforce this.
// A lookup that reaches the cache walks all entries of both generations, one entry per
// cycle, from the single read port of the entry RAM through the shared comparator,
// then passes a drain and a commit step. A clear or an over-long run skips the walk and
// goes straight to the commit step. s_axis_tready_o is high only while the sequencer is
// idle, so one item is in work at a time: the next is taken only once the last commits.
// The result register holds its item while m_axis_tready_i is low; a new item may be
// accepted meanwhile and waits in its commit step until the register is free.
// Reset empties both generations, zeroes the counters and loads the register defaults;
// the entry RAM needs no clearing pass, since valid bits gate every read.
module two_generation_run_cache_top #(
  parameter int unsigned SLOTS    = rcc_pkg::SLOTS_DEF,
  parameter int unsigned TAG_BITS = rcc_pkg::TAG_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] text_tag, [39:32] variant, [55:40] run_units
  input  logic [rcc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // [0] action
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [6:0] slot, [7] rotated, [39:8] hit_count, [71:40] miss_count
  output logic [rcc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // [2:0] status
  output logic [2:0]                      m_axis_tuser_o,
  input  logic                            cfg_we_i,
  input  logic [rcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rcc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned ENTRIES  = 2 * SLOTS;
  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
  localparam int unsigned CMP_W    = (CNT_W > rcc_pkg::CAPACITY_W) ? CNT_W : rcc_pkg::CAPACITY_W;
  localparam int unsigned KEY_BITS = (TAG_BITS < rcc_pkg::IN_TAG_W) ? TAG_BITS
                                                                     : rcc_pkg::IN_TAG_W;
  localparam int unsigned RAM_W    = KEY_BITS + rcc_pkg::VAR_W + rcc_pkg::RUN_W;
  localparam int unsigned SUM_W    = rcc_pkg::BUDGET_W + 1;

  // configuration
  logic [rcc_pkg::CAPACITY_W-1:0] capacity_q;
  logic [rcc_pkg::BUDGET_W-1:0]   budget_q;
  logic [rcc_pkg::RUN_W-1:0]      max_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= rcc_pkg::CAPACITY_RST;
      budget_q   <= rcc_pkg::BUDGET_RST;
      max_run_q  <= rcc_pkg::MAX_RUN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcc_pkg::REG_CAPACITY:    capacity_q <= cfg_wdata_i[rcc_pkg::CAPACITY_W-1:0];
        rcc_pkg::REG_UNIT_BUDGET: budget_q   <= cfg_wdata_i[rcc_pkg::BUDGET_W-1:0];
        rcc_pkg::REG_MAX_RUN:     max_run_q  <= cfg_wdata_i[rcc_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and item registers
  rcc_pkg::state_e state_q, state_d;
  logic                      s_accept;
  logic                      act_q;
  logic                      long_q;
  logic [KEY_BITS-1:0]       tag_q;
  logic [rcc_pkg::VAR_W-1:0] var_q;
  logic [rcc_pkg::RUN_W-1:0] units_q;
  logic [IDX_W-1:0]          cnt_q, cnt_d;
  logic                      pend_q, pend_d;
  logic [IDX_W-1:0]          pidx_q, pidx_d;
  logic                      scan_last;
  logic                      out_free;
  logic                      ram_re;
  logic                      scan_start;
  logic                      commit;

  assign s_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign scan_last = (cnt_q == IDX_W'(ENTRIES - 1));
  assign out_free  = !m_axis_tvalid_o || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rcc_pkg::S_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser_i == rcc_pkg::ACT_CLEAR ||
              s_axis_tdata_i[55:40] > max_run_q) begin
            state_d = rcc_pkg::S_COMMIT;
          end else begin
            state_d = rcc_pkg::S_SCAN;
          end
        end
      end
      rcc_pkg::S_SCAN: begin
        if (scan_last) begin
          state_d = rcc_pkg::S_DRAIN;
        end
      end
      rcc_pkg::S_DRAIN: state_d = rcc_pkg::S_COMMIT;
      rcc_pkg::S_COMMIT: begin
        if (out_free) begin
          state_d = rcc_pkg::S_IDLE;
        end
      end
      default: state_d = rcc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    scan_start      = 1'b0;
    ram_re          = 1'b0;
    commit          = 1'b0;
    pend_d          = 1'b0;
    pidx_d          = pidx_q;
    cnt_d           = cnt_q;
    case (state_q)
      rcc_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        scan_start      = s_axis_tvalid_i;
        cnt_d           = '0;
      end
      rcc_pkg::S_SCAN: begin
        ram_re = 1'b1;
        pend_d = 1'b1;
        pidx_d = cnt_q;
        cnt_d  = cnt_q + 1'b1;
      end
      rcc_pkg::S_DRAIN: ;
      rcc_pkg::S_COMMIT: commit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcc_pkg::S_IDLE;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    if (s_accept) begin
      act_q   <= s_axis_tuser_i;
      long_q  <= s_axis_tdata_i[55:40] > max_run_q;
      tag_q   <= s_axis_tdata_i[KEY_BITS-1:0];
      var_q   <= s_axis_tdata_i[39:32];
      units_q <= s_axis_tdata_i[55:40];
    end
  end

  // entry store: tag, variant and length in RAM; valid and hot bits in flops
  logic [ENTRIES-1:0]        valid_q, valid_d;
  logic [ENTRIES-1:0]        hot_q, hot_d;
  logic [RAM_W-1:0]          rd_data;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;

  rcc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({tag_q, var_q, units_q}),
    .re_i    (ram_re),
    .raddr_i (cnt_q),
    .rdata_o (rd_data)
  );

  rcc_pkg::scan_flags_t      flags;
  logic [IDX_W-1:0]          hot_idx;
  logic [IDX_W-1:0]          cold_idx;
  logic [rcc_pkg::RUN_W-1:0] cold_units;
  logic [IDX_W-1:0]          free_idx;
  logic [IDX_W-1:0]          free_rot_idx;

  rcc_scan #(
    .IDX_W    (IDX_W),
    .KEY_BITS (KEY_BITS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (scan_start),
    .pend_i         (pend_q),
    .idx_i          (pidx_q),
    .ent_valid_i    (valid_q[pidx_q]),
    .ent_hot_i      (hot_q[pidx_q]),
    .rd_tag_i       (rd_data[RAM_W-1 -: KEY_BITS]),
    .rd_var_i       (rd_data[rcc_pkg::RUN_W +: rcc_pkg::VAR_W]),
    .rd_units_i     (rd_data[rcc_pkg::RUN_W-1:0]),
    .key_tag_i      (tag_q),
    .key_var_i      (var_q),
    .flags_o        (flags),
    .hot_idx_o      (hot_idx),
    .cold_idx_o     (cold_idx),
    .cold_units_o   (cold_units),
    .free_idx_o     (free_idx),
    .free_rot_idx_o (free_rot_idx)
  );

  // commit step
  logic [CNT_W-1:0]            hot_count_q, hot_count_d;
  logic [rcc_pkg::BUDGET_W-1:0] hot_units_q, hot_units_d;
  logic [rcc_pkg::COUNT_W-1:0] hits_q, hits_d;
  logic [rcc_pkg::COUNT_W-1:0] misses_q, misses_d;
  logic [CMP_W-1:0]            cap_lim;
  logic [rcc_pkg::RUN_W-1:0]   inc_units;
  logic                        need_rot;
  logic                        free_ok;
  logic [IDX_W-1:0]            ins_idx;
  logic [IDX_W-1:0]            res_idx;
  logic                        res_rot;
  rcc_pkg::status_e            res_status;

  assign cap_lim   = (CMP_W'(capacity_q) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(capacity_q);
  assign inc_units = flags.cold_hit ? cold_units : units_q;
  assign need_rot  = !((CMP_W'(hot_count_q) < cap_lim) &&
                       (SUM_W'(hot_units_q) + SUM_W'(inc_units) <= SUM_W'(budget_q)));
  assign free_ok   = need_rot ? flags.free_rot : flags.free_any;
  assign ins_idx   = need_rot ? free_rot_idx : free_idx;

  always_comb begin
    valid_d     = valid_q;
    hot_d       = hot_q;
    hot_count_d = hot_count_q;
    hot_units_d = hot_units_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    res_status  = rcc_pkg::ST_CLEARED;
    res_idx     = '0;
    res_rot     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = ins_idx;
    if (act_q == rcc_pkg::ACT_CLEAR) begin
      valid_d     = '0;
      hot_d       = '0;
      hot_count_d = '0;
      hot_units_d = '0;
    end else if (long_q) begin
      misses_d   = misses_q + 1'b1;
      res_status = rcc_pkg::ST_LONG;
    end else if (flags.hot_hit) begin
      hits_d     = hits_q + 1'b1;
      res_status = rcc_pkg::ST_HOT_HIT;
      res_idx    = hot_idx;
    end else begin
      // promotion or insert: rotate first when hot is full or over budget with this run
      res_rot = need_rot;
      if (need_rot) begin
        valid_d     = valid_q & hot_q;
        hot_d       = '0;
        hot_count_d = '0;
        hot_units_d = '0;
      end
      if (flags.cold_hit) begin
        hits_d            = hits_q + 1'b1;
        res_status        = rcc_pkg::ST_COLD_HIT;
        res_idx           = cold_idx;
        valid_d[cold_idx] = 1'b1;
        hot_d[cold_idx]   = 1'b1;
        hot_count_d       = hot_count_d + 1'b1;
        hot_units_d       = hot_units_d + rcc_pkg::BUDGET_W'(cold_units);
      end else begin
        misses_d = misses_q + 1'b1;
        if (free_ok) begin
          res_status       = rcc_pkg::ST_MISS;
          res_idx          = ins_idx;
          ram_we           = commit;
          valid_d[ins_idx] = 1'b1;
          hot_d[ins_idx]   = 1'b1;
          hot_count_d      = hot_count_d + 1'b1;
          hot_units_d      = hot_units_d + rcc_pkg::BUDGET_W'(units_q);
        end else begin
          res_status = rcc_pkg::ST_LONG;
        end
      end
    end
  end

  logic                           m_valid_q;
  logic [rcc_pkg::OUT_DATA_W-1:0] m_data_q;
  logic [2:0]                     m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      hot_q       <= '0;
      hot_count_q <= '0;
      hot_units_q <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (commit) begin
        valid_q     <= valid_d;
        hot_q       <= hot_d;
        hot_count_q <= hot_count_d;
        hot_units_q <= hot_units_d;
        hits_q      <= hits_d;
        misses_q    <= misses_d;
        m_valid_q   <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      m_data_q <= {misses_d, hits_d, res_rot, rcc_pkg::SLOT_W'(res_idx)};
      m_user_q <= res_status;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // checks
  hot_count_tracks_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hot_count_q == CNT_W'($countones(valid_q & hot_q)))
    else $error("hot entry count out of step with hot bits");

  hot_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hot_q & ~valid_q) == '0)
    else $error("hot bit set on an invalid entry");

  result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == rcc_pkg::S_COMMIT))
    else $error("result raised outside the commit step");

  scan_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !s_axis_tready_o)
    else $error("entry compared while input is open");

endmodule
